### rtl/core/fill_link_master_sequencer_defines.svh
// ----------------------------------------------------------------------------
// Fill link master sequencer assertion macros
// Concurrent assertion helpers shared by the sequencer RTL.
// ----------------------------------------------------------------------------
`ifndef FILL_LINK_MASTER_SEQUENCER_DEFINES_SVH
`define FILL_LINK_MASTER_SEQUENCER_DEFINES_SVH

`ifndef SYNTHESIS

// Consequent must hold in the cycle after the antecedent.
`define FLMS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sequencer assertion failed");

// Consequent must hold in the same cycle as the antecedent.
`define FLMS_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sequencer assertion failed");

`else

`define FLMS_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`define FLMS_ASSERT_SAME(lbl, clk, rst, ante, cons)

`endif

`endif

### rtl/core/flms_pkg.sv
// ----------------------------------------------------------------------------
// Fill link master sequencer package
// Shared codes, event types and sizes for the sequencer modules.
// ----------------------------------------------------------------------------
package flms_pkg;

   localparam int TIME_BITS_DEFAULT = 16;

   localparam int REQ_TDATA_W = 80;
   localparam int REQ_TUSER_W = 5;
   localparam int RSP_TDATA_W = 16;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 8;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0]  WAIT_SECONDS_RESET = 8'd4;
   localparam logic [7:0]  OWN_ADDRESS_RESET  = 8'd1;
   localparam logic [7:0]  BROADCAST_ADDRESS  = 8'hFF;
   localparam logic [15:0] AXID_CODE_A        = 16'h0050;
   localparam logic [15:0] AXID_CODE_B        = 16'h0060;
   localparam logic [9:0]  HEADER_CHARS       = 10'd4;

   localparam logic [CSR_INDEX_W-1:0] CSR_WAIT_SECONDS = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_OWN_ADDRESS  = 1'b1;

   // Request operation codes.
   localparam logic [2:0] OP_START   = 3'd0;
   localparam logic [2:0] OP_POLL    = 3'd1;
   localparam logic [2:0] OP_U_FRAME = 3'd2;
   localparam logic [2:0] OP_S_FRAME = 3'd3;
   localparam logic [2:0] OP_I_CHUNK = 3'd4;
   localparam logic [2:0] OP_ADDRESS = 3'd5;

   // Command kinds within U and S frames.
   localparam logic [1:0] U_KIND_UA   = 2'd0;
   localparam logic [1:0] U_KIND_DISC = 2'd1;
   localparam logic [1:0] S_KIND_RR   = 2'd0;
   localparam logic [1:0] S_KIND_RNR  = 2'd1;

   typedef enum logic [2:0] {
      FR_NONE  = 3'd0,
      FR_SNRM  = 3'd1,
      FR_AXID  = 3'd2,
      FR_RR    = 3'd3,
      FR_DISC  = 3'd4,
      FR_BLOCK = 3'd5
   } frame_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_DONE    = 2'd1,
      ST_EXPIRED = 2'd2,
      ST_ERROR   = 2'd3
   } status_type;

   typedef enum logic [10:0] {
      PH_IDLE      = 11'b000_0000_0001,
      PH_CONNECT   = 11'b000_0000_0010,
      PH_AXID      = 11'b000_0000_0100,
      PH_REQ_DISC  = 11'b000_0000_1000,
      PH_RECONNECT = 11'b000_0001_0000,
      PH_CHECK_RR  = 11'b000_0010_0000,
      PH_SEND_DATA = 11'b000_0100_0000,
      PH_DISC      = 11'b000_1000_0000,
      PH_DONE      = 11'b001_0000_0000,
      PH_TIMEOUT   = 11'b010_0000_0000,
      PH_ERROR     = 11'b100_0000_0000
   } phase_type;

   // Event classes produced by the front end.
   typedef enum logic [3:0] {
      EV_START   = 4'd0,
      EV_POLL    = 4'd1,
      EV_UA      = 4'd2,
      EV_U_DISC  = 4'd3,
      EV_REFRESH = 4'd4,
      EV_RR      = 4'd5,
      EV_RNR     = 4'd6,
      EV_CHUNK   = 4'd7,
      EV_ADDRESS = 4'd8,
      EV_IGNORE  = 4'd9
   } event_kind_type;

   typedef struct packed {
      event_kind_type kind;
      logic [15:0]    now_seconds;
      logic [7:0]     block_total;
      logic           header_present;
      logic [15:0]    unit_code;
      logic [15:0]    unit_length;
      logic [9:0]     chars_raw;
      logic [9:0]     chars_hdr;
      logic           code_is_axid;
      logic [7:0]     peer_address;
      logic           is_unnumbered_ua;
   } event_type;

   typedef struct packed {
      frame_type   send_frame;
      logic [7:0]  block_number;
      status_type  link_status;
      logic        sequence_reset;
      logic        address_ok;
   } result_type;

endpackage

### rtl/core/fill_link_master_sequencer.sv
// ----------------------------------------------------------------------------
// Fill link master sequencer
// Master side of a key-fill link: connect, exchange, reconnect, send blocks.
// ----------------------------------------------------------------------------
// Every request beat is one event and yields exactly one response beat. The
// block takes one beat per clock when the response side does not stall; the
// phase machine in the back end settles each event as it is taken, so a
// steady stream runs at one beat per cycle when nothing stalls. An accepted
// request beat is loaded into the front-end decode register, then into the
// event queue and then into the response register. The two-entry queue lets
// requests keep arriving for a while when the response side stalls.
module fill_link_master_sequencer
   import flms_pkg::*;
#(
   parameter int TIME_BITS = TIME_BITS_DEFAULT
)
(
   input  logic                   clock,
   input  logic                   reset,
   // Request beats.
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // now_seconds[15:0], block_total[23:16], header_present[24],
   // unit_code[40:25], unit_length[56:41], chunk_chars[66:57],
   // peer_address_in[74:67], is_unnumbered_ua[75], zero fill[79:76]
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // operation[2:0], command_kind[4:3]
   input  logic [REQ_TUSER_W-1:0] req_tuser,
   // Response beats.
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // send_frame[2:0], block_number[10:3], link_status[12:11],
   // sequence_reset[13], address_ok[14], zero fill[15]
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   // Configuration writes.
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

`include "fill_link_master_sequencer_defines.svh"

   logic      front_valid;
   logic      front_ready;
   event_type front_event;
   logic      back_valid;
   logic      back_ready;
   event_type back_event;

   flms_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .ev_valid   (front_valid),
      .ev_ready   (front_ready),
      .ev_data    (front_event)
   );

   flms_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_data   (front_event),
      .out_valid (back_valid),
      .out_ready (back_ready),
      .out_data  (back_event)
   );

   flms_back #(
      .TIME_BITS (TIME_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .ev_valid   (back_valid),
      .ev_ready   (back_ready),
      .ev_data    (back_event),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // An accepted request beat is held in the front-end register next cycle.
   `FLMS_ASSERT_NEXT(a_front_loads, clock, reset, req_tvalid && req_tready, front_valid)
   // An event taken by the back end shows up as a response next cycle.
   `FLMS_ASSERT_NEXT(a_back_responds, clock, reset, back_valid && back_ready, rsp_tvalid)
   // Block numbers are only reported alongside a data block frame.
   `FLMS_ASSERT_SAME(a_block_number, clock, reset, rsp_tvalid && (rsp_tdata[2:0] != FR_BLOCK), rsp_tdata[10:3] == 8'd0)

endmodule

### rtl/core/flms_front.sv
// ----------------------------------------------------------------------------
// Fill link master sequencer front end
// Takes request beats, decodes the operation and registers a classified event.
// ----------------------------------------------------------------------------
module flms_front
   import flms_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic [REQ_TUSER_W-1:0] req_tuser,
   output logic                   ev_valid,
   input  logic                   ev_ready,
   output event_type              ev_data
);

   logic      valid_ff;
   logic      valid_in;
   event_type event_ff;
   event_type event_in;
   logic      load;
   logic [2:0] operation;
   logic [1:0] command_kind;

   assign operation    = req_tuser[2:0];
   assign command_kind = req_tuser[4:3];

   assign req_tready = !valid_ff || ev_ready;
   assign load       = req_tvalid && req_tready;
   assign valid_in   = load || (valid_ff && !ev_ready);

   always_comb begin
      event_in.now_seconds      = req_tdata[15:0];
      event_in.block_total      = req_tdata[23:16];
      event_in.header_present   = req_tdata[24];
      event_in.unit_code        = req_tdata[40:25];
      event_in.unit_length      = req_tdata[56:41];
      event_in.chars_raw        = req_tdata[66:57];
      event_in.peer_address     = req_tdata[74:67];
      event_in.is_unnumbered_ua = req_tdata[75];
      // Header bytes come off the chunk, never below zero.
      event_in.chars_hdr = (req_tdata[66:57] > HEADER_CHARS) ?
                           req_tdata[66:57] - HEADER_CHARS : 10'd0;
      event_in.code_is_axid = (req_tdata[40:25] == AXID_CODE_A) ||
                              (req_tdata[40:25] == AXID_CODE_B);
      event_in.kind = EV_IGNORE;
      unique case (operation)
         OP_START: begin
            event_in.kind = EV_START;
         end
         OP_POLL: begin
            event_in.kind = EV_POLL;
         end
         OP_U_FRAME: begin
            if (command_kind == U_KIND_UA) begin
               event_in.kind = EV_UA;
            end else if (command_kind == U_KIND_DISC) begin
               event_in.kind = EV_U_DISC;
            end else begin
               event_in.kind = EV_REFRESH;
            end
         end
         OP_S_FRAME: begin
            if (command_kind == S_KIND_RR) begin
               event_in.kind = EV_RR;
            end else if (command_kind == S_KIND_RNR) begin
               event_in.kind = EV_RNR;
            end else begin
               event_in.kind = EV_REFRESH;
            end
         end
         OP_I_CHUNK: begin
            event_in.kind = EV_CHUNK;
         end
         OP_ADDRESS: begin
            event_in.kind = EV_ADDRESS;
         end
         default: begin
            event_in.kind = EV_IGNORE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         event_ff <= event_in;
      end
   end

   assign ev_valid = valid_ff;
   assign ev_data  = event_ff;

endmodule

### rtl/core/flms_queue.sv
// ----------------------------------------------------------------------------
// Fill link master sequencer event queue
// Small FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module flms_queue
   import flms_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   output logic      in_ready,
   input  event_type in_data,
   output logic      out_valid,
   input  logic      out_ready,
   output event_type out_data
);

   event_type              entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0] wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff;
   logic [QUEUE_PTR_W-1:0] rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff;
   logic [QUEUE_CNT_W-1:0] count_in;
   logic                   push;
   logic                   pop;

   assign in_ready  = (count_ff != QUEUE_CNT_W'(QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 :
                     wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 :
                     rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

### rtl/core/flms_back.sv
// ----------------------------------------------------------------------------
// Fill link master sequencer back end
// Runs the link phase machine on each event and holds the result register.
// ----------------------------------------------------------------------------
module flms_back
   import flms_pkg::*;
#(
   parameter int TIME_BITS = TIME_BITS_DEFAULT
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic                   ev_valid,
   output logic                   ev_ready,
   input  event_type              ev_data,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   logic [7:0]           wait_seconds_ff;
   logic [7:0]           own_address_ff;

   phase_type            phase_ff;
   phase_type            phase_in;
   logic [TIME_BITS-1:0] deadline_ff;
   logic [TIME_BITS-1:0] deadline_in;
   logic [7:0]           blocks_left_ff;
   logic [7:0]           blocks_left_in;
   logic [7:0]           blocks_sent_ff;
   logic [7:0]           blocks_sent_in;
   logic [15:0]          unit_remaining_ff;
   logic [15:0]          unit_remaining_in;
   logic [15:0]          unit_code_ff;
   logic [15:0]          unit_code_in;
   logic [7:0]           link_address_ff;
   logic [7:0]           link_address_in;

   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   result_type           result_ff;
   result_type           result_in;

   logic                 take;
   logic [TIME_BITS-1:0] now_t;
   logic [TIME_BITS-1:0] armed;
   logic [TIME_BITS-1:0] elapsed;
   logic                 passed;
   logic                 header_take;
   logic [15:0]          remain_base;
   logic [15:0]          chunk_chars;
   logic                 code_axid;

   assign ev_ready     = !rsp_valid_ff || rsp_tready;
   assign take         = ev_valid && ev_ready;
   assign rsp_valid_in = take || (rsp_valid_ff && !rsp_tready);

   assign now_t   = TIME_BITS'(ev_data.now_seconds);
   assign armed   = now_t + TIME_BITS'(wait_seconds_ff);
   assign elapsed = now_t - deadline_ff;
   // The deadline lies behind us when the wrapped distance is nonzero and in the lower half.
   assign passed  = (elapsed != '0) && !elapsed[TIME_BITS-1];

   assign header_take = ev_data.header_present && (unit_remaining_ff == 16'd0);
   assign remain_base = header_take ? ev_data.unit_length : unit_remaining_ff;
   assign chunk_chars = header_take ? {6'd0, ev_data.chars_hdr} :
                                      {6'd0, ev_data.chars_raw};
   assign code_axid   = header_take ? ev_data.code_is_axid :
                        ((unit_code_ff == AXID_CODE_A) || (unit_code_ff == AXID_CODE_B));

   always_comb begin
      phase_in          = phase_ff;
      deadline_in       = deadline_ff;
      blocks_left_in    = blocks_left_ff;
      blocks_sent_in    = blocks_sent_ff;
      unit_remaining_in = unit_remaining_ff;
      unit_code_in      = unit_code_ff;
      link_address_in   = link_address_ff;
      result_in.send_frame     = FR_NONE;
      result_in.block_number   = 8'd0;
      result_in.link_status    = ST_OK;
      result_in.sequence_reset = 1'b0;
      result_in.address_ok     = 1'b0;

      unique case (ev_data.kind)
         EV_START: begin
            blocks_left_in    = ev_data.block_total;
            blocks_sent_in    = 8'd0;
            unit_remaining_in = 16'd0;
            result_in.sequence_reset = 1'b1;
            phase_in          = PH_IDLE;
            link_address_in   = own_address_ff;
            deadline_in       = armed;
         end
         EV_POLL: begin
            if (phase_ff == PH_IDLE) begin
               unit_remaining_in = 16'd0;
               result_in.sequence_reset = 1'b1;
               result_in.send_frame     = FR_SNRM;
               deadline_in = armed;
               phase_in    = PH_CONNECT;
            end else if (passed) begin
               phase_in = (phase_ff == PH_CONNECT) ? PH_TIMEOUT : PH_ERROR;
            end
         end
         EV_UA, EV_RR: begin
            deadline_in = armed;
            if ((ev_data.kind == EV_UA) && (phase_ff == PH_CONNECT)) begin
               result_in.send_frame = FR_AXID;
               phase_in = PH_AXID;
            end else if ((ev_data.kind == EV_UA) && (phase_ff == PH_RECONNECT)) begin
               unit_remaining_in = 16'd0;
               result_in.sequence_reset = 1'b1;
               result_in.send_frame     = FR_SNRM;
               phase_in = PH_CHECK_RR;
            end else if ((ev_data.kind == EV_RR) && (phase_ff == PH_REQ_DISC)) begin
               result_in.send_frame = FR_DISC;
               phase_in = PH_RECONNECT;
            end else if (phase_ff == PH_CHECK_RR) begin
               result_in.send_frame = FR_RR;
               phase_in = PH_SEND_DATA;
            end else if (phase_ff == PH_SEND_DATA) begin
               if (blocks_left_ff != 8'd0) begin
                  result_in.send_frame   = FR_BLOCK;
                  result_in.block_number = blocks_sent_ff;
                  blocks_sent_in = blocks_sent_ff + 8'd1;
                  blocks_left_in = blocks_left_ff - 8'd1;
               end else begin
                  result_in.send_frame = FR_DISC;
                  phase_in = PH_DISC;
               end
            end else if (phase_ff == PH_DISC) begin
               unit_remaining_in = 16'd0;
               result_in.sequence_reset = 1'b1;
               phase_in = PH_DONE;
            end
         end
         EV_U_DISC: begin
            unit_remaining_in = 16'd0;
            result_in.sequence_reset = 1'b1;
            phase_in    = PH_DONE;
            deadline_in = armed;
         end
         EV_REFRESH: begin
            deadline_in = armed;
         end
         EV_RNR: begin
            result_in.send_frame = FR_RR;
            deadline_in = armed;
         end
         EV_CHUNK: begin
            if (header_take) begin
               unit_code_in = ev_data.unit_code;
            end
            unit_remaining_in = (remain_base > chunk_chars) ?
                                remain_base - chunk_chars : 16'd0;
            if (code_axid) begin
               phase_in = PH_REQ_DISC;
            end
            result_in.send_frame = FR_RR;
            deadline_in = armed;
         end
         EV_ADDRESS: begin
            if ((ev_data.peer_address == BROADCAST_ADDRESS) ||
                (ev_data.peer_address == link_address_ff)) begin
               result_in.address_ok = 1'b1;
            end else if (ev_data.is_unnumbered_ua) begin
               link_address_in      = ev_data.peer_address;
               result_in.address_ok = 1'b1;
            end
         end
         default: begin
         end
      endcase

      if (phase_in == PH_TIMEOUT) begin
         result_in.link_status = ST_EXPIRED;
      end else if (phase_in == PH_DONE) begin
         result_in.link_status = ST_DONE;
      end else if (phase_in == PH_ERROR) begin
         result_in.link_status = ST_ERROR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wait_seconds_ff <= WAIT_SECONDS_RESET;
         own_address_ff  <= OWN_ADDRESS_RESET;
      end else if (csr_we) begin
         if (csr_index == CSR_WAIT_SECONDS) begin
            wait_seconds_ff <= csr_wdata;
         end
         if (csr_index == CSR_OWN_ADDRESS) begin
            own_address_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= PH_IDLE;
         deadline_ff       <= '0;
         blocks_left_ff    <= 8'd0;
         blocks_sent_ff    <= 8'd0;
         unit_remaining_ff <= 16'd0;
         unit_code_ff      <= 16'd0;
         link_address_ff   <= OWN_ADDRESS_RESET;
         rsp_valid_ff      <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (take) begin
            phase_ff          <= phase_in;
            deadline_ff       <= deadline_in;
            blocks_left_ff    <= blocks_left_in;
            blocks_sent_ff    <= blocks_sent_in;
            unit_remaining_ff <= unit_remaining_in;
            unit_code_ff      <= unit_code_in;
            link_address_ff   <= link_address_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         result_ff <= result_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, result_ff.address_ok, result_ff.sequence_reset,
                        result_ff.link_status, result_ff.block_number,
                        result_ff.send_frame};

endmodule
